// ===== design/tcrc_pkg.sv =====
// Shared types and constants for the triangle centroid radius check.
package tcrc_pkg;

  localparam int COORD_W   = 24;
  localparam int SUM_W     = 26;
  localparam int MAG_W     = 26;
  localparam int RAD_W     = 52;
  localparam int DIST_W    = 25;
  localparam int CNT_W     = 24;
  localparam int NUM_AXES  = 3;
  localparam int NUM_LANES = 3;

  // floor(r / 3) = (r * RECIP3) >> RECIP_SHIFT for every r below 2^27
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'((64'd1 << RECIP_SHIFT) / 3 + 1);

  localparam logic [DIST_W-1:0] LIMIT_RESET = DIST_W'(4096);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic [CNT_W-1:0]          count_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
  } in_t;

  typedef struct packed {
    count_t     tri_number;
    dist_t      dist_a;
    dist_t      dist_b;
    dist_t      dist_c;
    logic [2:0] fail_bits;
    dist_t      least_seen;
    dist_t      most_seen;
    count_t     fail_total;
  } out_t;

endpackage

// ===== design/tcrc_lane.sv =====
// One vertex lane: squared distance, iterative square root, divide by three.
module tcrc_lane
  import tcrc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  coord_t vertex   [NUM_AXES],
  input  sum_t   axis_sum [NUM_AXES],
  output logic   done,
  output dist_t  vtx_dist
);

  localparam int ROOT_W          = RAD_W / 2;
  localparam int PAIRS_PER_CYCLE = 2;
  localparam int ROOT_CYCLES     = ROOT_W / PAIRS_PER_CYCLE;
  localparam int ITER_W          = $clog2(ROOT_CYCLES);
  localparam int REM_W           = ROOT_W + 4;
  localparam int PROD_W          = ROOT_W + RECIP_W;

  typedef enum logic [2:0] {L_IDLE, L_SQR, L_ADD, L_ROOT, L_DIV, L_DONE} lane_state_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } step_t;

  lane_state_t       state;
  logic [MAG_W-1:0]  mag [NUM_AXES];
  logic [RAD_W-1:0]  sq  [NUM_AXES];
  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [ITER_W-1:0] iter;

  logic [MAG_W-1:0]  mag_next [NUM_AXES];
  step_t             step_one;
  step_t             step_two;
  logic [PROD_W-1:0] prod;

  // One restoring digit of the square root: bring down two bits, try 4*root+1.
  function automatic step_t root_step(input logic [REM_W-1:0] rem_in,
                                      input logic [ROOT_W-1:0] root_in,
                                      input logic [1:0] pair);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    step_t            r;
    cur   = {rem_in[REM_W-3:0], pair};
    trial = {2'b00, root_in, 2'b01};
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {root_in[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {root_in[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      logic signed [SUM_W:0] tri_v;
      logic signed [SUM_W:0] diff;
      tri_v = ((SUM_W+1)'(vertex[k]) <<< 1) + (SUM_W+1)'(vertex[k]);
      diff  = tri_v - (SUM_W+1)'(axis_sum[k]);
      mag_next[k] = diff[SUM_W] ? MAG_W'(-diff) : MAG_W'(diff);
    end
  end

  assign step_one = root_step(rem, root, rad[RAD_W-1 -: 2]);
  assign step_two = root_step(step_one.rem, step_one.root, rad[RAD_W-3 -: 2]);
  assign prod     = PROD_W'(root) * PROD_W'(RECIP3);
  assign done     = (state == L_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      case (state)
        L_IDLE: begin
          if (start) begin
            mag   <= mag_next;
            state <= L_SQR;
          end
        end
        L_SQR: begin
          for (int k = 0; k < NUM_AXES; k++) begin
            sq[k] <= RAD_W'(mag[k]) * RAD_W'(mag[k]);
          end
          state <= L_ADD;
        end
        L_ADD: begin
          rad   <= sq[0] + sq[1] + sq[2];
          rem   <= '0;
          root  <= '0;
          iter  <= '0;
          state <= L_ROOT;
        end
        L_ROOT: begin
          rem  <= step_two.rem;
          root <= step_two.root;
          rad  <= rad << (2 * PAIRS_PER_CYCLE);
          iter <= iter + 1'b1;
          if (iter == ITER_W'(ROOT_CYCLES - 1)) begin
            state <= L_DIV;
          end
        end
        L_DIV: begin
          vtx_dist <= prod[RECIP_SHIFT +: DIST_W];
          state    <= L_DONE;
        end
        L_DONE: begin
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/tcrc_merge.sv =====
// Merge stage: limit check, running statistics and the output register.
module tcrc_merge
  import tcrc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  dist_t lane_dist [NUM_LANES],
  input  dist_t limit_distance,
  output logic  free,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  dist_t      running_min;
  dist_t      running_max;
  count_t     fail_counter;
  count_t     tri_counter;

  dist_t      low3;
  dist_t      high3;
  dist_t      running_min_next;
  dist_t      running_max_next;
  logic [2:0] fails;
  logic [1:0] fail_count;
  logic [CNT_W:0] fail_sum;
  count_t     fail_counter_next;

  always_comb begin
    low3  = (lane_dist[0] < lane_dist[1]) ? lane_dist[0] : lane_dist[1];
    low3  = (lane_dist[2] < low3) ? lane_dist[2] : low3;
    high3 = (lane_dist[0] > lane_dist[1]) ? lane_dist[0] : lane_dist[1];
    high3 = (lane_dist[2] > high3) ? lane_dist[2] : high3;
    running_min_next = (low3 < running_min) ? low3 : running_min;
    running_max_next = (high3 > running_max) ? high3 : running_max;
    for (int j = 0; j < NUM_LANES; j++) begin
      fails[j] = lane_dist[j] > limit_distance;
    end
    fail_count = 2'(fails[0]) + 2'(fails[1]) + 2'(fails[2]);
    fail_sum   = (CNT_W+1)'(fail_counter) + (CNT_W+1)'(fail_count);
    // saturate at full scale
    fail_counter_next = fail_sum[CNT_W] ? '1 : fail_sum[CNT_W-1:0];
  end

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      running_min  <= '1;
      running_max  <= '0;
      fail_counter <= '0;
      tri_counter  <= '0;
    end else begin
      if (load) begin
        out_valid           <= 1'b1;
        running_min         <= running_min_next;
        running_max         <= running_max_next;
        fail_counter        <= fail_counter_next;
        tri_counter         <= tri_counter + 1'b1;
        out_data.tri_number <= tri_counter;
        out_data.dist_a     <= lane_dist[0];
        out_data.dist_b     <= lane_dist[1];
        out_data.dist_c     <= lane_dist[2];
        out_data.fail_bits  <= fails;
        out_data.least_seen <= running_min_next;
        out_data.most_seen  <= running_max_next;
        out_data.fail_total <= fail_counter_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/triangle_centroid_radius_check_core.sv =====
// Top level: input capture, axis sums, three vertex lanes and the merge stage.
// The core takes one triangle at a time; the next is accepted once the result is merged.
// The square root (two result bits per cycle in each lane) is the longest step of a lane.
// A new triangle is accepted while the previous result still waits at the output.
// Reset (rst, synchronous): limit 4096, minimum all ones, maximum, counters zero.
module triangle_centroid_radius_check_core
  import tcrc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_write,
  input  dist_t cfg_data,
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  typedef enum logic [2:0] {S_IDLE, S_SUM, S_START, S_RUN, S_MERGE} core_state_t;

  core_state_t          state;
  dist_t                limit_distance;
  coord_t               verts   [NUM_LANES][NUM_AXES];
  sum_t                 axis_sum [NUM_AXES];
  logic                 lane_start;
  logic [NUM_LANES-1:0] lane_done;
  dist_t                lane_dist [NUM_LANES];
  logic                 merge_load;
  logic                 merge_free;

  assign in_ready   = (state == S_IDLE);
  assign lane_start = (state == S_START);
  assign merge_load = (state == S_MERGE) && merge_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_distance <= LIMIT_RESET;
    end else if (cfg_write) begin
      limit_distance <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            verts[0][0] <= in_data.a_x;
            verts[0][1] <= in_data.a_y;
            verts[0][2] <= in_data.a_z;
            verts[1][0] <= in_data.b_x;
            verts[1][1] <= in_data.b_y;
            verts[1][2] <= in_data.b_z;
            verts[2][0] <= in_data.c_x;
            verts[2][1] <= in_data.c_y;
            verts[2][2] <= in_data.c_z;
            state       <= S_SUM;
          end
        end
        S_SUM: begin
          for (int k = 0; k < NUM_AXES; k++) begin
            axis_sum[k] <= SUM_W'(verts[0][k]) + SUM_W'(verts[1][k]) + SUM_W'(verts[2][k]);
          end
          state <= S_START;
        end
        S_START: begin
          state <= S_RUN;
        end
        S_RUN: begin
          // lanes run in lockstep; lane zero speaks for all
          if (lane_done[0]) begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (merge_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tcrc_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .start    (lane_start),
      .vertex   (verts[g]),
      .axis_sum (axis_sum),
      .done     (lane_done[g]),
      .vtx_dist (lane_dist[g])
    );
  end

  tcrc_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .load           (merge_load),
    .lane_dist      (lane_dist),
    .limit_distance (limit_distance),
    .free           (merge_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    lane_done == '0 || lane_done == '1)
    else $error("lanes finished out of step");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] |-> state == S_RUN)
    else $error("lane finished outside run state");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    merge_load |=> out_valid)
    else $error("merged result not presented");

endmodule
